// ===== src/rmv_pkg.sv =====
`default_nettype none
package rmv_pkg;

	// field widths fixed by the ports
	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = 32;
	localparam int SUM_W    = 48;
	localparam int SUMSQ_W  = 63;
	localparam int MEAN_W   = 32;
	localparam int VAR_W    = 48;

	// parameter defaults
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF  = 32;
	localparam int FRAC_BITS_DEF    = 16;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;

	// back end datapath
	localparam int ACC_W      = 112;
	localparam int DIV_W      = 64;
	localparam int CHUNK_W    = 16;
	localparam int MUL_A_W    = 48;
	localparam int MUL_PROD_W = MUL_A_W + CHUNK_W;
	localparam int STEP_W     = 4;
	localparam int MUL_LAST   = 8;
	localparam int DIV_ITER_W = 6;
	localparam int VAR_ITERS  = 48;
	localparam int MEAN_ITERS = 32;

	typedef struct packed {
		logic                       accepted;
		logic [CNT_W-1:0]           cnt;
		logic signed [SUM_W-1:0]    sum;
		logic [SUMSQ_W-1:0]         sumsq;
		logic                       ovf;
	} rmv_entry_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_ITER_W-1:0] iters;
	} div_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_VSTART,
		S_VDIV,
		S_MSTART,
		S_MDIV,
		S_DONE
	} back_state_t;

endpackage
`default_nettype wire

// ===== src/rmv_front.sv =====
`default_nettype none
module rmv_front #(
	parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = rmv_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [rmv_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                         fifo_full,
	output logic                              push,
	output rmv_pkg::rmv_entry_t               push_data
);

	logic [COUNT_WIDTH-1:0]              count_q;
	logic signed [rmv_pkg::SUM_W-1:0]    sum_q;
	logic [rmv_pkg::SUMSQ_W-1:0]         sumsq_q;
	logic                                ovf_q;

	logic [SAMPLE_WIDTH-1:0]             raw;
	logic signed [SAMPLE_WIDTH-1:0]      d;
	logic [SAMPLE_WIDTH-1:0]             mag;
	logic [2*SAMPLE_WIDTH-1:0]           sq;
	logic [rmv_pkg::DIV_W-1:0]           room;
	logic                                ok;
	logic                                fire;
	logic [COUNT_WIDTH-1:0]              count_nx;
	logic signed [rmv_pkg::SUM_W-1:0]    sum_nx;
	logic [rmv_pkg::SUMSQ_W-1:0]         sumsq_nx;
	logic                                ovf_nx;

	// sample magnitude and square
	always_comb begin
		raw = sample[SAMPLE_WIDTH-1:0];
		d   = signed'(raw);
		mag = raw[SAMPLE_WIDTH-1] ? (~raw + 1'b1) : raw;
		sq  = mag * mag;
	end

	// classify: full count or full sum of squares rejects the sample
	always_comb begin
		room     = {1'b0, {rmv_pkg::SUMSQ_W{1'b1}}} - rmv_pkg::DIV_W'(sq);
		ok       = !(&count_q) && ({1'b0, sumsq_q} < room);
		count_nx = ok ? count_q + 1'b1 : count_q;
		sum_nx   = ok ? sum_q + rmv_pkg::SUM_W'(d) : sum_q;
		sumsq_nx = ok ? sumsq_q + rmv_pkg::SUMSQ_W'(sq) : sumsq_q;
		ovf_nx   = ovf_q | !ok;
	end

	assign in_ready = !fifo_full;
	assign fire     = in_valid && in_ready;
	assign push     = fire;

	always_comb begin
		push_data.accepted = ok;
		push_data.cnt      = rmv_pkg::CNT_W'(count_nx);
		push_data.sum      = sum_nx;
		push_data.sumsq    = sumsq_nx;
		push_data.ovf      = ovf_nx;
	end

	// accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			ovf_q   <= 1'b0;
		end else if (fire) begin
			count_q <= count_nx;
			sum_q   <= sum_nx;
			sumsq_q <= sumsq_nx;
			ovf_q   <= ovf_nx;
		end
	end

endmodule
`default_nettype wire

// ===== src/rmv_fifo.sv =====
`default_nettype none
module rmv_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire rmv_pkg::rmv_entry_t  push_data,
	output logic                      full,
	input  wire logic                 pop,
	output rmv_pkg::rmv_entry_t       pop_data,
	output logic                      empty
);

	localparam int PTR_W = (rmv_pkg::FIFO_DEPTH > 1) ? $clog2(rmv_pkg::FIFO_DEPTH) : 1;
	localparam int LVL_W = $clog2(rmv_pkg::FIFO_DEPTH + 1);

	rmv_pkg::rmv_entry_t mem_q [rmv_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]    wptr_q;
	logic [PTR_W-1:0]    rptr_q;
	logic [LVL_W-1:0]    level_q;

	assign full     = (level_q == LVL_W'(rmv_pkg::FIFO_DEPTH));
	assign empty    = (level_q == '0);
	assign pop_data = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(rmv_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(rmv_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/rmv_div.sv =====
`default_nettype none
module rmv_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rmv_pkg::div_ctl_t             ctl,
	input  wire logic [rmv_pkg::DIV_W-1:0]     rem_init,
	input  wire logic [rmv_pkg::DIV_W-1:0]     num_lo,
	input  wire logic [rmv_pkg::DIV_W-1:0]     divisor,
	output logic                               done,
	output logic [rmv_pkg::VAR_W-1:0]          quot
);

	logic [rmv_pkg::DIV_W-1:0]      rem_q;
	logic [rmv_pkg::DIV_W-1:0]      lo_q;
	logic [rmv_pkg::DIV_W-1:0]      d_q;
	logic [rmv_pkg::VAR_W-1:0]      quot_q;
	logic [rmv_pkg::DIV_ITER_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [rmv_pkg::DIV_W:0]        rem2;
	logic [rmv_pkg::DIV_W:0]        diff;
	logic                           ge;
	logic [rmv_pkg::DIV_W-1:0]      rem_nx;

	// one restoring step: shift in the next numerator bit, trial subtract
	always_comb begin
		rem2   = {rem_q, lo_q[rmv_pkg::DIV_W-1]};
		diff   = rem2 - {1'b0, d_q};
		ge     = (rem2 >= {1'b0, d_q});
		rem_nx = ge ? diff[rmv_pkg::DIV_W-1:0] : rem2[rmv_pkg::DIV_W-1:0];
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			cnt_q  <= ctl.iters;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == rmv_pkg::DIV_ITER_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= rem_init;
			lo_q   <= num_lo;
			d_q    <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			lo_q   <= {lo_q[rmv_pkg::DIV_W-2:0], 1'b0};
			quot_q <= {quot_q[rmv_pkg::VAR_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

// ===== src/rmv_back.sv =====
`default_nettype none
module rmv_back #(
	parameter int FRAC_BITS = rmv_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         fifo_empty,
	output logic                              fifo_pop,
	input  wire rmv_pkg::rmv_entry_t          pop_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              accepted,
	output logic [rmv_pkg::CNT_W-1:0]         sample_count,
	output logic signed [rmv_pkg::SUM_W-1:0]  running_sum,
	output logic signed [rmv_pkg::MEAN_W-1:0] mean_q16,
	output logic [rmv_pkg::VAR_W-1:0]         variance_q16,
	output logic                              variance_valid,
	output logic                              overflow_seen
);

	localparam int DW = rmv_pkg::DIV_W;

	rmv_pkg::back_state_t        state_q, state_nx;
	rmv_pkg::rmv_entry_t         ent_q;
	logic [rmv_pkg::STEP_W-1:0]  step_q;
	logic [rmv_pkg::ACC_W-1:0]   acc_q;
	logic [DW-1:0]               dv_q;
	logic [rmv_pkg::VAR_W-1:0]   var_q;
	logic [rmv_pkg::MEAN_W-1:0]  mean_q;

	logic                        out_valid_q;
	logic                        acc_out_q;
	logic [rmv_pkg::CNT_W-1:0]   cnt_out_q;
	logic signed [rmv_pkg::SUM_W-1:0] sum_out_q;
	logic [rmv_pkg::MEAN_W-1:0]  mean_out_q;
	logic [rmv_pkg::VAR_W-1:0]   var_out_q;
	logic                        vval_out_q;
	logic                        ovf_out_q;

	logic                        neg;
	logic [rmv_pkg::SUM_W-1:0]   smag;
	logic [rmv_pkg::CNT_W-1:0]   nm1;
	logic                        ph_a, ph_b;
	logic [1:0]                  ch;
	logic [rmv_pkg::MUL_A_W-1:0] mul_a;
	logic [DW-1:0]               b_src;
	logic [rmv_pkg::CHUNK_W-1:0] mul_b;
	logic [rmv_pkg::MUL_PROD_W-1:0] prod;
	logic [rmv_pkg::ACC_W-1:0]   prod_sh;
	logic [rmv_pkg::ACC_W-1:0]   num_v;
	logic [DW-1:0]               num_hi;
	logic [DW-1:0]               num_m;
	logic                        n_ge1, n_ge2, sat;
	logic                        out_free;
	logic                        load_out;
	rmv_pkg::div_ctl_t           div_ctl;
	logic [DW-1:0]               div_rem;
	logic [DW-1:0]               div_lo;
	logic [DW-1:0]               div_d;
	logic                        div_done;
	logic [rmv_pkg::VAR_W-1:0]   div_quot;

	// operands taken from the current transaction
	always_comb begin
		neg   = ent_q.sum[rmv_pkg::SUM_W-1];
		smag  = neg ? rmv_pkg::SUM_W'(-ent_q.sum) : rmv_pkg::SUM_W'(ent_q.sum);
		nm1   = ent_q.cnt - 1'b1;
		n_ge1 = (ent_q.cnt != '0);
		n_ge2 = (ent_q.cnt >= rmv_pkg::CNT_W'(2));
	end

	// shared 48x16 multiplier: n*sumsq, then sum^2, then n*(n-1), one chunk a cycle
	always_comb begin
		ph_a = (step_q < rmv_pkg::STEP_W'(4));
		ph_b = !ph_a && (step_q < rmv_pkg::STEP_W'(7));
		if (ph_a) begin
			ch = step_q[1:0];
		end else if (ph_b) begin
			ch = 2'(step_q - rmv_pkg::STEP_W'(4));
		end else begin
			ch = 2'(step_q - rmv_pkg::STEP_W'(7));
		end
		mul_a   = ph_b ? smag : rmv_pkg::MUL_A_W'(ent_q.cnt);
		b_src   = ph_a ? {1'b0, ent_q.sumsq} :
		          ph_b ? DW'(smag) : DW'(nm1);
		mul_b   = b_src[{ch, 4'b0000} +: rmv_pkg::CHUNK_W];
		prod    = mul_a * mul_b;
		prod_sh = rmv_pkg::ACC_W'(prod) << {ch, 4'b0000};
	end

	// divider operands
	always_comb begin
		num_v  = acc_q << FRAC_BITS;
		num_hi = num_v[rmv_pkg::ACC_W-1 -: DW];
		sat    = (num_hi >= dv_q);
		num_m  = DW'(smag) << FRAC_BITS;
		if (state_q == rmv_pkg::S_VSTART) begin
			div_rem = num_hi;
			div_lo  = {num_v[rmv_pkg::VAR_W-1:0], {(DW - rmv_pkg::VAR_W){1'b0}}};
			div_d   = dv_q;
		end else begin
			div_rem = {{(DW - rmv_pkg::MEAN_ITERS){1'b0}}, num_m[DW-1 -: rmv_pkg::MEAN_ITERS]};
			div_lo  = {num_m[rmv_pkg::MEAN_ITERS-1:0], {(DW - rmv_pkg::MEAN_ITERS){1'b0}}};
			div_d   = DW'(ent_q.cnt);
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rmv_pkg::S_IDLE:   if (!fifo_empty) state_nx = rmv_pkg::S_MUL;
			rmv_pkg::S_MUL:    if (step_q == rmv_pkg::STEP_W'(rmv_pkg::MUL_LAST))
			                   	state_nx = rmv_pkg::S_VSTART;
			rmv_pkg::S_VSTART: state_nx = (n_ge2 && !sat) ? rmv_pkg::S_VDIV : rmv_pkg::S_MSTART;
			rmv_pkg::S_VDIV:   if (div_done) state_nx = rmv_pkg::S_MSTART;
			rmv_pkg::S_MSTART: state_nx = n_ge1 ? rmv_pkg::S_MDIV : rmv_pkg::S_DONE;
			rmv_pkg::S_MDIV:   if (div_done) state_nx = rmv_pkg::S_DONE;
			rmv_pkg::S_DONE:   if (out_free) state_nx = rmv_pkg::S_IDLE;
			default:           state_nx = rmv_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		fifo_pop      = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.iters = rmv_pkg::DIV_ITER_W'(rmv_pkg::MEAN_ITERS);
		load_out      = 1'b0;
		case (state_q)
			rmv_pkg::S_IDLE:   fifo_pop = !fifo_empty;
			rmv_pkg::S_VSTART: begin
				div_ctl.start = n_ge2 && !sat;
				div_ctl.iters = rmv_pkg::DIV_ITER_W'(rmv_pkg::VAR_ITERS);
			end
			rmv_pkg::S_MSTART: div_ctl.start = n_ge1;
			rmv_pkg::S_DONE:   load_out = out_free;
			default:           fifo_pop = 1'b0;
		endcase
	end

	rmv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.rem_init (div_rem),
		.num_lo   (div_lo),
		.divisor  (div_d),
		.done     (div_done),
		.quot     (div_quot)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmv_pkg::S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (fifo_pop) begin
				step_q <= '0;
			end else if (state_q == rmv_pkg::S_MUL) begin
				step_q <= step_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			ent_q <= pop_data;
			acc_q <= '0;
			dv_q  <= '0;
		end else if (state_q == rmv_pkg::S_MUL) begin
			if (ph_a) begin
				acc_q <= acc_q + prod_sh;
			end else if (ph_b) begin
				acc_q <= acc_q - prod_sh;
			end else begin
				dv_q <= dv_q + prod_sh[DW-1:0];
			end
		end
		if (state_q == rmv_pkg::S_VSTART) begin
			var_q <= !n_ge2 ? '0 : {rmv_pkg::VAR_W{1'b1}};
		end else if (state_q == rmv_pkg::S_VDIV && div_done) begin
			var_q <= div_quot;
		end
		if (state_q == rmv_pkg::S_MSTART) begin
			mean_q <= '0;
		end else if (state_q == rmv_pkg::S_MDIV && div_done) begin
			mean_q <= neg ? -div_quot[rmv_pkg::MEAN_W-1:0] : div_quot[rmv_pkg::MEAN_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			acc_out_q  <= ent_q.accepted;
			cnt_out_q  <= ent_q.cnt;
			sum_out_q  <= ent_q.sum;
			mean_out_q <= mean_q;
			var_out_q  <= var_q;
			vval_out_q <= n_ge2;
			ovf_out_q  <= ent_q.ovf;
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = acc_out_q;
	assign sample_count   = cnt_out_q;
	assign running_sum    = sum_out_q;
	assign mean_q16       = signed'(mean_out_q);
	assign variance_q16   = var_out_q;
	assign variance_valid = vval_out_q;
	assign overflow_seen  = ovf_out_q;

`ifndef NO_ASSERTIONS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> state_q == rmv_pkg::S_IDLE)
		else $error("queue popped outside idle");
	a_done_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == rmv_pkg::S_VDIV || state_q == rmv_pkg::S_MDIV))
		else $error("divider finished with no division pending");
	a_vval_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && vval_out_q) |-> cnt_out_q >= rmv_pkg::CNT_W'(2))
		else $error("variance valid below two samples");
	a_var_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !vval_out_q) |-> var_out_q == '0)
		else $error("invalid variance not zero");
`endif

endmodule
`default_nettype wire

// ===== src/running_mean_variance.sv =====
// channel  | valid     | ready     | payload
// ---------+-----------+-----------+-----------------------------------------------
// input    | in_valid  | in_ready  | sample
// result   | out_valid | out_ready | accepted, sample_count, running_sum, mean_q16,
//          |           |           | variance_q16, variance_valid, overflow_seen
//
// a transaction is classified and accumulated in the cycle it is accepted
// the back end works on one transaction at a time: the chunked 48x16 multiplier,
// then the 48-step variance division and the 32-step mean division on the serial
// restoring divider; a two-entry queue sits between the ends
// arst_n clears the statistics, the sticky overflow flag, the queue and both state machines
// a stalled result holds in the output register; the front accepts until the queue fills
`default_nettype none
module running_mean_variance #(
	parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = rmv_pkg::COUNT_WIDTH_DEF,
	parameter int FRAC_BITS    = rmv_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [rmv_pkg::SAMPLE_W-1:0] sample,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              accepted,
	output logic [rmv_pkg::CNT_W-1:0]         sample_count,
	output logic signed [rmv_pkg::SUM_W-1:0]  running_sum,
	output logic signed [rmv_pkg::MEAN_W-1:0] mean_q16,
	output logic [rmv_pkg::VAR_W-1:0]         variance_q16,
	output logic                              variance_valid,
	output logic                              overflow_seen
);

	logic                push;
	logic                pop;
	logic                full;
	logic                empty;
	rmv_pkg::rmv_entry_t push_data;
	rmv_pkg::rmv_entry_t pop_data;

	// front: accept, classify, accumulate
	rmv_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.fifo_full (full),
		.push      (push),
		.push_data (push_data)
	);

	// snapshot queue
	rmv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// back: mean and variance
	rmv_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.fifo_empty     (empty),
		.fifo_pop       (pop),
		.pop_data       (pop_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.sample_count   (sample_count),
		.running_sum    (running_sum),
		.mean_q16       (mean_q16),
		.variance_q16   (variance_q16),
		.variance_valid (variance_valid),
		.overflow_seen  (overflow_seen)
	);

endmodule
`default_nettype wire
